/* design/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, types and round functions for the byte stream hash.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[idx];
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

/* design/sha256_sched.sv */
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word sliding window that yields one schedule word per round.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                    clk_i,
  input  logic                    advance_i,
  input  logic                    load_i,
  input  sha256_pkg::word_t       load_word_i,
  output sha256_pkg::word_t       w_o
);

  sha256_pkg::word_t win_q [16];
  sha256_pkg::word_t nxt;

  assign w_o = win_q[0];
  assign nxt = win_q[0] + sha256_pkg::ssig0(win_q[1]) + win_q[9]
             + sha256_pkg::ssig1(win_q[14]);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= load_word_i;
    end else if (advance_i) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= nxt;
    end
  end

endmodule

/* design/sha256_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Loads a block from the byte memory, runs 64 rounds, updates the chain.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              reinit_i,
  output logic              busy_o,
  output logic [5:0]        rd_addr_o,
  input  logic [7:0]        rd_data_i,
  input  logic [2:0]        hidx_i,
  output sha256_pkg::word_t hword_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StLoad  = 2'd1;
  localparam logic [1:0] StRound = 2'd2;
  localparam logic [1:0] StFold  = 2'd3;

  logic [1:0]        st_q, st_d;
  logic [6:0]        cnt_q, cnt_d;
  sha256_pkg::word_t h_q [8];
  sha256_pkg::word_t v_q [8];
  logic [23:0]       acc_q;
  logic              ld_q;
  logic              ld_word;
  sha256_pkg::word_t w;
  sha256_pkg::word_t t1, t2;

  assign busy_o    = (st_q != StIdle);
  assign rd_addr_o = cnt_q[5:0];
  assign hword_o   = h_q[hidx_i];
  assign ld_word   = ld_q && (cnt_q[1:0] == 2'd0);

  sha256_sched u_sched (
    .clk_i      (clk_i),
    .advance_i  (st_q == StRound),
    .load_i     (ld_word),
    .load_word_i({acc_q, rd_data_i}),
    .w_o        (w)
  );

  assign t1 = v_q[7] + sha256_pkg::bsig1(v_q[4])
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha256_pkg::round_k(cnt_q[5:0]) + w;
  assign t2 = sha256_pkg::bsig0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          st_d  = StLoad;
          cnt_d = '0;
        end
      end
      StLoad: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          st_d  = StRound;
          cnt_d = '0;
        end
      end
      StRound: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) st_d = StFold;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cnt_q <= '0;
      ld_q  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_hash(3'(i));
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ld_q  <= (st_q == StLoad) && (cnt_q != 7'd64);
      if (reinit_i) begin
        for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_hash(3'(i));
      end else if (st_q == StFold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_q) acc_q <= {acc_q[15:0], rd_data_i};
    if (st_q == StLoad && cnt_q == 7'd64) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (st_q == StRound) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

endmodule

/* design/sha256_byte_stream_hash.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hash
// Byte-wide message in, eight 32-bit digest words out per message.
// ----------------------------------------------------------------------------
// channel  dir  tdata                      tuser / tlast
// s_axis   in   [7:0] data_byte            tuser: byte_present, tlast: end
// m_axis   out  [31:0] digest_word         tuser: word_index, tlast: last_word
// Bytes enter one per cycle while s_axis_tready is high; a full block
// stalls input while the core loads it, runs 64 rounds and folds. An end
// beat writes padding one byte per cycle, compresses one or two blocks,
// then streams 8 digest words held while m_axis_tready is low. Async reset.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  localparam logic [2:0] StIn   = 3'd0;
  localparam logic [2:0] StComp = 3'd1;
  localparam logic [2:0] StPad  = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;
  localparam logic [2:0] StWait = 3'd4;

  logic [2:0]  st_q, st_d;
  logic        fin_q, fin_d;
  logic        lenok_q, lenok_d;
  logic        last_q, last_d;
  logic        eom_q, eom_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q;
  logic [2:0]  oidx_q, oidx_d;
  logic [7:0]  mem [64];
  logic [7:0]  rd_q;
  logic        we;
  logic [7:0]  wd;
  logic [5:0]  rd_addr;
  logic        start, reinit, busy;
  logic [7:0]  pad_byte;
  sha256_pkg::word_t hword;

  always_ff @(posedge clk_i) begin
    if (we) mem[fill_q] <= wd;
    rd_q <= mem[rd_addr];
  end

  sha256_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .reinit_i (reinit),
    .busy_o   (busy),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_q),
    .hidx_i   (oidx_q),
    .hword_o  (hword)
  );

  always_comb begin
    pad_byte = 8'h00;
    if (!fin_q) pad_byte = 8'h80;
    else if (lenok_q && fill_q >= 6'd56) pad_byte = len_q[{~fill_q[2:0], 3'b111} -: 8];
  end

  assign s_axis_tready = (st_q == StIn);
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata  = hword;
  assign m_axis_tuser  = oidx_q;
  assign m_axis_tlast  = (oidx_q == 3'd7);

  always_comb begin
    st_d    = st_q;
    fin_d   = fin_q;
    lenok_d = lenok_q;
    last_d  = last_q;
    eom_d   = eom_q;
    fill_d  = fill_q;
    bits_d  = bits_q;
    oidx_d  = oidx_q;
    we      = 1'b0;
    wd      = s_axis_tdata;
    start   = 1'b0;
    reinit  = 1'b0;
    unique case (st_q)
      StIn: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            we     = 1'b1;
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + 64'd8;
            if (fill_q == 6'd63) begin
              start = 1'b1;
              eom_d = s_axis_tlast;
              st_d  = StComp;
            end else if (s_axis_tlast) begin
              st_d = StPad;
            end
          end else if (s_axis_tlast) begin
            st_d = StPad;
          end
        end
      end
      StPad: begin
        we     = 1'b1;
        wd     = pad_byte;
        fin_d  = 1'b1;
        fill_d = fill_q + 6'd1;
        if (!fin_q && fill_q <= 6'd55) lenok_d = 1'b1;
        if (fill_q == 6'd63) begin
          start = 1'b1;
          st_d  = StComp;
          if (lenok_q) last_d = 1'b1;
          else lenok_d = 1'b1;
        end
      end
      StComp: begin
        st_d = StWait;
      end
      StWait: begin
        if (!busy) begin
          if (last_q) begin
            st_d   = StOut;
            oidx_d = '0;
          end else if (eom_q || fin_q) begin
            eom_d = 1'b0;
            st_d  = StPad;
          end else begin
            st_d = StIn;
          end
        end
      end
      StOut: begin
        if (m_axis_tready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            reinit  = 1'b1;
            fin_d   = 1'b0;
            lenok_d = 1'b0;
            last_d  = 1'b0;
            bits_d  = '0;
            st_d    = StIn;
          end
        end
      end
      default: st_d = StIn;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIn;
      fin_q   <= 1'b0;
      lenok_q <= 1'b0;
      last_q  <= 1'b0;
      eom_q   <= 1'b0;
      fill_q  <= '0;
      bits_q  <= '0;
      oidx_q  <= '0;
    end else begin
      st_q    <= st_d;
      fin_q   <= fin_d;
      lenok_q <= lenok_d;
      last_q  <= last_d;
      eom_q   <= eom_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      oidx_q  <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIn && s_axis_tvalid && s_axis_tlast) begin
      len_q <= bits_q + (s_axis_tuser ? 64'd8 : 64'd0);
    end
  end

endmodule
